// File: sv/mpv_pkg.sv
// Package: shared types, constants and SHA-256 helpers for the Merkle path verifier.
`default_nettype none
package mpv_pkg;
	localparam int NodeIndexBitsDefault = 32;
	localparam logic [63:0] FieldPrime = 64'hFFFF_FFFF_0000_0001;

	localparam logic [1:0] MODE_START   = 2'd0;
	localparam logic [1:0] MODE_ELEMENT = 2'd1;
	localparam logic [1:0] MODE_SIBLING = 2'd2;

	localparam logic [2:0] CFG_EXT_MODE = 3'd0;
	localparam logic [2:0] CFG_ROOT_0   = 3'd1;
	localparam logic [2:0] CFG_ROOT_1   = 3'd2;
	localparam logic [2:0] CFG_ROOT_2   = 3'd3;
	localparam logic [2:0] CFG_ROOT_3   = 3'd4;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] node_index;
		logic [63:0] word_0;
		logic [63:0] word_1;
		logic [63:0] word_2;
		logic [63:0] word_3;
		logic        last;
	} item_t;

	typedef logic [255:0] state_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		round_k = k[i];
	endfunction

	localparam state_t ShaInit = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	function automatic logic [63:0] canonical(input logic [63:0] x);
		canonical = (x >= FieldPrime) ? x - FieldPrime : x;
	endfunction
endpackage
`default_nettype wire

// File: sv/mpv_sha_core.sv
// SHA-256 compression unit: one round per cycle over a 512-bit block.
`default_nettype none
module mpv_sha_core
	import mpv_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire state_t       chain_in,
	input  wire logic [511:0] block,
	output logic              done,
	output state_t            chain_out
);
	logic         busy_q;
	logic [5:0]   rnd_q;
	logic [511:0] w_q;
	state_t       v_q;
	state_t       h_q;
	logic [31:0]  a, b, c, d, e, f, g, h, w0, t1, t2, s0, s1, wn;

	always_comb begin
		{a, b, c, d, e, f, g, h} = v_q;
		w0 = w_q[511:480];
		t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
			+ round_k(rnd_q) + w0;
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
		s0 = rotr(w_q[479:448], 7) ^ rotr(w_q[479:448], 18) ^ (w_q[479:448] >> 3);
		s1 = rotr(w_q[63:32], 17) ^ rotr(w_q[63:32], 19) ^ (w_q[63:32] >> 10);
		wn = w0 + s0 + w_q[223:192] + s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			w_q <= block;
			v_q <= chain_in;
			h_q <= chain_in;
		end else if (busy_q) begin
			w_q <= {w_q[479:0], wn};
			v_q <= {t1 + t2, a, b, c, d + t1, e, f, g};
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++)
			chain_out[255 - 32*i -: 32] = h_q[255 - 32*i -: 32] + v_q[255 - 32*i -: 32];
	end
endmodule
`default_nettype wire

// File: sv/mpv_queue.sv
// Two-entry item queue between the front end and the verify engine.
`default_nettype none
module mpv_queue
	import mpv_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire item_t in_item,
	output logic       out_valid,
	input  wire logic  out_ready,
	output item_t      out_item
);
	item_t     mem_q [2];
	logic      wp_q, rp_q;
	logic [1:0] cnt_q;
	logic      push, pop;

	assign in_ready  = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_item  = mem_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// File: sv/mpv_engine.sv
// Verify engine: absorbs elements and siblings, pads, hashes, compares with root.
`default_nettype none
module mpv_engine
	import mpv_pkg::*;
#(
	parameter int NODE_INDEX_BITS = NodeIndexBitsDefault
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         item_valid,
	output logic              item_ready,
	input  wire item_t        item,
	input  wire logic         ext_mode,
	input  wire logic [255:0] root,
	output logic              res_valid,
	input  wire logic         res_ready,
	output logic              res_matched,
	output logic              res_seq_err
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ABS   = 3'd1;
	localparam logic [2:0] ST_HASH  = 3'd2;
	localparam logic [2:0] ST_FIN   = 3'd3;
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_COL   = 2'd1;
	localparam logic [1:0] PH_PATH  = 2'd2;

	logic [2:0]   st_q;
	logic [1:0]   phase_q;
	logic [511:0] blk_q;
	logic [63:0]  cnt_q;
	logic [127:0] bytes_q;
	logic [4:0]   nleft_q;
	logic [2:0]   fin_q;
	logic         after_q;
	logic         lastel_q;
	logic         sib_q;
	state_t       chain_q, dig_q;
	logic [NODE_INDEX_BITS-1:0] idx_q;
	logic [63:0]  bitlen_q;
	logic         sha_start, sha_done;
	state_t       sha_out;
	logic [5:0]   pos;

	assign pos = cnt_q[5:0];
	assign item_ready = (st_q == ST_IDLE) && !res_valid;

	mpv_sha_core u_sha (
		.clk(clk), .arst_n(arst_n), .start(sha_start), .chain_in(chain_q),
		.block(blk_q), .done(sha_done), .chain_out(sha_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			phase_q   <= PH_IDLE;
			cnt_q     <= '0;
			idx_q     <= '0;
			chain_q   <= ShaInit;
			res_valid <= 1'b0;
			res_matched <= 1'b0;
			res_seq_err <= 1'b0;
			sha_start <= 1'b0;
			nleft_q <= '0;
			fin_q <= '0;
			after_q <= 1'b0;
			lastel_q <= 1'b0;
			sib_q <= 1'b0;
			bitlen_q <= '0;
		end else begin
			sha_start <= 1'b0;
			if (res_valid && res_ready) res_valid <= 1'b0;
			case (st_q)
				ST_IDLE: if (item_valid && item_ready) begin
					case (item.mode)
						MODE_START: begin
							chain_q <= ShaInit;
							cnt_q   <= '0;
							idx_q   <= NODE_INDEX_BITS'(item.node_index);
							phase_q <= PH_COL;
						end
						MODE_ELEMENT: if (phase_q != PH_COL) begin
							res_valid <= 1'b1; res_matched <= 1'b0; res_seq_err <= 1'b1;
							phase_q <= PH_IDLE;
						end else begin
							bytes_q <= {canonical(item.word_0), canonical(item.word_1)};
							nleft_q <= ext_mode ? 5'd16 : 5'd8;
							lastel_q <= item.last;
							sib_q <= 1'b0;
							st_q <= ST_ABS;
						end
						MODE_SIBLING: if (phase_q != PH_PATH) begin
							res_valid <= 1'b1; res_matched <= 1'b0; res_seq_err <= 1'b1;
							phase_q <= PH_IDLE;
						end else begin
							chain_q <= ShaInit;
							cnt_q <= 64'd64;
							blk_q <= idx_q[0] ?
								{item.word_0, item.word_1, item.word_2, item.word_3, dig_q} :
								{dig_q, item.word_0, item.word_1, item.word_2, item.word_3};
							idx_q <= idx_q >> 1;
							lastel_q <= item.last;
							sib_q <= 1'b1;
							after_q <= 1'b0;
							fin_q <= 3'd0;
							sha_start <= 1'b1;
							st_q <= ST_HASH;
						end
						default: begin
							res_valid <= 1'b1; res_matched <= 1'b0; res_seq_err <= 1'b1;
							phase_q <= PH_IDLE;
						end
					endcase
				end
				ST_ABS: begin
					blk_q[511 - 8*pos -: 8] <= bytes_q[127:120];
					bytes_q <= bytes_q << 8;
					cnt_q <= cnt_q + 64'd1;
					nleft_q <= nleft_q - 5'd1;
					if (pos == 6'd63) begin
						after_q <= (nleft_q != 5'd1) || lastel_q;
						fin_q <= 3'd0;
						sha_start <= 1'b1;
						st_q <= ST_HASH;
					end else if (nleft_q == 5'd1) begin
						if (lastel_q) begin
							bitlen_q <= {cnt_q[60:0] + 61'd1, 3'b000};
							after_q <= 1'b0;
							fin_q <= 3'd1;
							st_q <= ST_FIN;
						end else
							st_q <= ST_IDLE;
					end
				end
				ST_HASH: if (sha_done) begin
					chain_q <= sha_out;
					if (sib_q && !after_q) begin
						bitlen_q <= 64'd512;
						fin_q <= 3'd1;
						st_q <= ST_FIN;
					end else if (fin_q == 3'd2) begin
						dig_q <= sha_out;
						if (sib_q ? lastel_q : (idx_q == NODE_INDEX_BITS'(1))) begin
							res_valid <= 1'b1;
							res_matched <= (sha_out == root);
							res_seq_err <= 1'b0;
							phase_q <= PH_IDLE;
						end else
							phase_q <= PH_PATH;
						st_q <= ST_IDLE;
					end else if (fin_q == 3'd1) begin
						st_q <= ST_FIN;
					end else if (nleft_q != 5'd0) begin
						st_q <= ST_ABS;
					end else if (lastel_q) begin
						bitlen_q <= {cnt_q[60:0], 3'b000};
						after_q <= 1'b0;
						fin_q <= 3'd1;
						st_q <= ST_FIN;
					end else
						st_q <= ST_IDLE;
				end
				ST_FIN: begin
					// pad one byte per cycle: 0x80, zeros, then length
					if (fin_q == 3'd1 && pos != 6'd0 || fin_q == 3'd1 && !after_q) begin
						blk_q[511 - 8*pos -: 8] <= after_q ? 8'h00 : 8'h80;
						after_q <= 1'b1;
						cnt_q <= cnt_q + 64'd1;
						if (pos == 6'd63) begin
							sha_start <= 1'b1;
							st_q <= ST_HASH;
						end else if (pos + 6'd1 == 6'd56) begin
							blk_q[63:0] <= bitlen_q;
							fin_q <= 3'd2;
							sha_start <= 1'b1;
							st_q <= ST_HASH;
						end
					end else begin
						blk_q[511 - 8*pos -: 8] <= 8'h00;
						cnt_q <= cnt_q + 64'd1;
						if (pos == 6'd55) begin
							blk_q[63:0] <= bitlen_q;
							fin_q <= 3'd2;
							sha_start <= 1'b1;
							st_q <= ST_HASH;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: sv/merkle_path_verify_sha256_top.sv
// Top level: input stream, configuration registers, item queue and verify engine.
//
// channel   dir  fields
// s_axis    in   tdata: mode, node_index, word_0..word_3 ; tlast: last
// m_axis    out  tdata: matched, sequence_error
// cfg       in   wr_en, wr_index, wr_data
//
// An element is accepted and its 8 or 16 bytes are absorbed, with a compression
// for each block it fills. The last element adds padding and a compression,
// two when the padding spills into a new block. A sibling takes two
// compressions, the second over a padding block, on the single shared
// SHA-256 round unit. A pending result holds the input until it is taken; a
// two-entry queue lets the input side run ahead. Reset clears control state.
`default_nettype none
module merkle_path_verify_sha256_top
	import mpv_pkg::*;
#(
	parameter int NODE_INDEX_BITS = NodeIndexBitsDefault
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [295:0] s_axis_tdata,  // mode, node_index, word_0..word_3
	input  wire logic         s_axis_tlast,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [7:0]        m_axis_tdata,  // matched, sequence_error
	input  wire logic         wr_en,
	input  wire logic [2:0]   wr_index,
	input  wire logic [63:0]  wr_data
);
	logic         ext_q;
	logic [255:0] root_q;
	item_t        in_item, q_item;
	logic         q_valid, q_ready, matched, seq_err;

	always_comb begin
		in_item.mode       = s_axis_tdata[1:0];
		in_item.node_index = s_axis_tdata[33:2];
		in_item.word_0     = s_axis_tdata[97:34];
		in_item.word_1     = s_axis_tdata[161:98];
		in_item.word_2     = s_axis_tdata[225:162];
		in_item.word_3     = s_axis_tdata[289:226];
		in_item.last       = s_axis_tlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q  <= 1'b0;
			root_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				CFG_EXT_MODE: ext_q <= wr_data[0];
				CFG_ROOT_0:   root_q[255:192] <= wr_data;
				CFG_ROOT_1:   root_q[191:128] <= wr_data;
				CFG_ROOT_2:   root_q[127:64]  <= wr_data;
				CFG_ROOT_3:   root_q[63:0]    <= wr_data;
				default: ;
			endcase
		end
	end

	mpv_queue u_queue (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_item(in_item), .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
	);

	mpv_engine #(.NODE_INDEX_BITS(NODE_INDEX_BITS)) u_engine (
		.clk(clk), .arst_n(arst_n), .item_valid(q_valid), .item_ready(q_ready),
		.item(q_item), .ext_mode(ext_q), .root(root_q), .res_valid(m_axis_tvalid),
		.res_ready(m_axis_tready), .res_matched(matched), .res_seq_err(seq_err)
	);

	assign m_axis_tdata = {6'd0, seq_err, matched};
endmodule
`default_nettype wire

// File: bench/tb_merkle_path_verify_sha256_top.sv
// Testbench for the Merkle path verifier: stream driver, result monitor and SHA-256 path predictor.
`timescale 1ns / 100ps
module tb_merkle_path_verify_sha256_top;
	import mpv_pkg::*;

	localparam int CycleLimit = 3000000;
	localparam int DrainCycles = 1000;

	typedef enum logic [1:0] {PH_IDLE, PH_COLUMN, PH_PATH} path_phase_t;
	typedef struct packed {
		logic matched;
		logic seq_err;
	} verdict_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [295:0] s_axis_tdata = '0;
	logic         s_axis_tlast = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [7:0]   m_axis_tdata;
	logic         wr_en = 1'b0;
	logic [2:0]   wr_index = '0;
	logic [63:0]  wr_data = '0;

	merkle_path_verify_sha256_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	localparam logic [31:0] RoundConst [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [255:0] sha256(input logic [7:0] msg[$]);
		logic [31:0] h [8];
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, s0, s1;
		logic [63:0] bit_len;
		int blk, i;
		bit_len = 64'(msg.size()) << 3;
		msg = {msg, 8'h80};
		while (msg.size() % 64 != 56)
			msg = {msg, 8'h00};
		for (i = 0; i < 8; i++)
			msg = {msg, bit_len[63 - 8 * i -: 8]};
		for (i = 0; i < 8; i++)
			h[i] = ShaInit[255 - 32 * i -: 32];
		for (blk = 0; blk < msg.size() / 64; blk++) begin
			for (i = 0; i < 16; i++)
				w[i] = {msg[blk * 64 + 4 * i], msg[blk * 64 + 4 * i + 1],
					msg[blk * 64 + 4 * i + 2], msg[blk * 64 + 4 * i + 3]};
			for (i = 16; i < 64; i++) begin
				s0 = ror32(w[i - 15], 7) ^ ror32(w[i - 15], 18) ^ (w[i - 15] >> 3);
				s1 = ror32(w[i - 2], 17) ^ ror32(w[i - 2], 19) ^ (w[i - 2] >> 10);
				w[i] = w[i - 16] + s0 + w[i - 7] + s1;
			end
			v = h;
			for (i = 0; i < 64; i++) begin
				t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i];
				t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
			end
			for (i = 0; i < 8; i++)
				h[i] = h[i] + v[i];
		end
		return {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
	endfunction

	function automatic logic [63:0] reduce_elem(input logic [63:0] x);
		return (x >= FieldPrime) ? x - FieldPrime : x;
	endfunction

	function automatic void push64(ref logic [7:0] q[$], input logic [63:0] v);
		for (int i = 0; i < 8; i++)
			q = {q, v[63 - 8 * i -: 8]};
	endfunction

	function automatic logic [255:0] node_hash(input logic cur_right, input logic [255:0] cur,
		input logic [255:0] sib);
		logic [511:0] pair;
		logic [7:0] q[$];
		pair = cur_right ? {sib, cur} : {cur, sib};
		for (int i = 0; i < 64; i++)
			q = {q, pair[511 - 8 * i -: 8]};
		return sha256(q);
	endfunction

	// predictor state
	logic          ext_mode = 1'b0;
	logic [255:0]  root_val = '0;
	path_phase_t   ph = PH_IDLE;
	logic [31:0]   cur_idx = '0;
	logic [7:0]    leaf_bytes[$];
	logic [255:0]  cur_dig = '0;
	verdict_t      verdicts[$];

	item_t         pending[$];
	item_t         cur_item;
	bit            taken = 1'b0;
	int            send_idle = 0;
	int            recv_idle = 0;
	int            fails = 0;
	int            cycles = 0;

	task automatic apply_item(input item_t it);
		bit has;
		verdict_t r;
		has = 1'b0;
		r = '0;
		case (it.mode)
			MODE_START: begin
				leaf_bytes.delete();
				cur_idx = it.node_index;
				ph = PH_COLUMN;
			end
			MODE_ELEMENT: begin
				if (ph != PH_COLUMN) begin
					has = 1'b1;
					r.seq_err = 1'b1;
				end else begin
					push64(leaf_bytes, reduce_elem(it.word_0));
					if (ext_mode)
						push64(leaf_bytes, reduce_elem(it.word_1));
					if (it.last) begin
						cur_dig = sha256(leaf_bytes);
						if (cur_idx == 32'd1) begin
							has = 1'b1;
							r.matched = (cur_dig == root_val);
						end else begin
							ph = PH_PATH;
						end
					end
				end
			end
			MODE_SIBLING: begin
				if (ph != PH_PATH) begin
					has = 1'b1;
					r.seq_err = 1'b1;
				end else begin
					cur_dig = node_hash(cur_idx[0], cur_dig,
						{it.word_0, it.word_1, it.word_2, it.word_3});
					cur_idx = cur_idx >> 1;
					if (it.last) begin
						has = 1'b1;
						r.matched = (cur_dig == root_val);
					end
				end
			end
			default: begin
				has = 1'b1;
				r.seq_err = 1'b1;
			end
		endcase
		if (has) begin
			verdicts = {verdicts, r};
			ph = PH_IDLE;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			apply_item(cur_item);
			taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (!s_axis_tvalid || taken) begin
			taken = 1'b0;
			if (arst_n && pending.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
				cur_item = pending.pop_front();
				s_axis_tdata = {6'b0, cur_item.word_3, cur_item.word_2, cur_item.word_1,
					cur_item.word_0, cur_item.node_index, cur_item.mode};
				s_axis_tlast = cur_item.last;
				s_axis_tvalid = 1'b1;
			end else begin
				s_axis_tvalid = 1'b0;
			end
		end
		m_axis_tready = ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin
		verdict_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (verdicts.size() == 0) begin
				$error("unexpected transfer, tdata %h", m_axis_tdata);
				fails++;
			end else begin
				e = verdicts.pop_front();
				if (m_axis_tdata[0] !== e.matched) begin
					$error("matched: expected %0b, actual %0b", e.matched, m_axis_tdata[0]);
					fails++;
				end
				if (m_axis_tdata[1] !== e.seq_err) begin
					$error("sequence_error: expected %0b, actual %0b", e.seq_err,
						m_axis_tdata[1]);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 7))
			0: return '1;
			1: return FieldPrime + 64'($urandom_range(0, 3));
			2: return FieldPrime - 64'd1;
			3: return '0;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic void add_item(input logic [1:0] mode, input logic [31:0] idx,
		input logic [255:0] words, input logic last);
		item_t it;
		it.mode = mode;
		it.node_index = idx;
		{it.word_0, it.word_1, it.word_2, it.word_3} = words;
		it.last = last;
		pending = {pending, it};
	endfunction

	function automatic logic [255:0] rand_words();
		return {rand_word(), rand_word(), rand_word(), rand_word()};
	endfunction

	// queue one well-formed opening and return the root it computes to
	function automatic logic [255:0] add_path(input logic ext);
		logic [7:0] col[$];
		logic [255:0] words, dig;
		logic [31:0] idx;
		int ncol, nsib;
		case ($urandom_range(0, 3))
			0: idx = 32'd1;
			1: idx = $urandom;
			default: idx = 32'($urandom_range(0, 64));
		endcase
		ncol = $urandom_range(1, 4);
		nsib = (idx == 32'd1) ? 0 : $urandom_range(1, 6);
		add_item(MODE_START, idx, rand_words(), 1'($urandom));
		for (int c = 0; c < ncol; c++) begin
			words = rand_words();
			add_item(MODE_ELEMENT, {$urandom}, words, c == ncol - 1);
			push64(col, reduce_elem(words[255:192]));
			if (ext)
				push64(col, reduce_elem(words[191:128]));
		end
		dig = sha256(col);
		for (int s = 0; s < nsib; s++) begin
			words = rand_words();
			add_item(MODE_SIBLING, {$urandom}, words, s == nsib - 1);
			dig = node_hash(idx[0], dig, words);
			idx = idx >> 1;
		end
		return dig;
	endfunction

	task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data);
		@(negedge clk);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = data;
		@(negedge clk);
		wr_en = 1'b0;
		case (idx)
			CFG_EXT_MODE: ext_mode = data[0];
			CFG_ROOT_0: root_val[255:192] = data;
			CFG_ROOT_1: root_val[191:128] = data;
			CFG_ROOT_2: root_val[127:64] = data;
			CFG_ROOT_3: root_val[63:0] = data;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic ext, input logic [255:0] root);
		cfg_write(CFG_EXT_MODE, {63'b0, ext});
		cfg_write(CFG_ROOT_0, root[255:192]);
		cfg_write(CFG_ROOT_1, root[191:128]);
		cfg_write(CFG_ROOT_2, root[127:64]);
		cfg_write(CFG_ROOT_3, root[63:0]);
	endtask

	task automatic drain();
		wait (pending.size() == 0 && !s_axis_tvalid && verdicts.size() == 0);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic random_phase(input logic ext, input int count);
		logic [255:0] root;
		logic [255:0] unused;
		item_t held[$];
		int base;
		base = pending.size();
		root = add_path(ext);
		while (pending.size() - base < count) begin
			if ($urandom_range(0, 4) != 0) begin
				unused = add_path(ext);
			end else begin
				add_item(2'($urandom), $urandom, rand_words(), 1'($urandom));
			end
		end
		// hold items back until the block takes the new root
		held = pending;
		pending.delete();
		set_config(ext, root);
		pending = held;
	endtask

	initial begin
		logic [7:0] col[$];
		logic [255:0] ones;
		ones = '1;
		send_idle = 33;
		recv_idle = 52;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_config(1'b0, '0);
		push64(col, reduce_elem('1));
		set_config(1'b0, sha256(col));
		add_item(MODE_ELEMENT, 32'd1, ones, 1'b1);
		add_item(MODE_SIBLING, 32'd1, ones, 1'b1);
		add_item(2'd3, 32'd1, ones, 1'b0);
		add_item(MODE_START, 32'd1, '0, 1'b0);
		add_item(MODE_ELEMENT, 32'd0, ones, 1'b1);
		add_item(MODE_START, 32'd5, '0, 1'b1);
		add_item(MODE_ELEMENT, 32'd0, ones, 1'b0);
		add_item(MODE_START, 32'd0, '0, 1'b0);
		add_item(MODE_ELEMENT, 32'd0, {FieldPrime, ones[191:0]}, 1'b1);
		add_item(MODE_SIBLING, 32'd0, ones, 1'b0);
		add_item(MODE_SIBLING, 32'd0, '0, 1'b0);
		add_item(MODE_SIBLING, 32'd0, rand_words(), 1'b1);
		add_item(MODE_START, 32'hFFFF_FFFF, ones, 1'b0);
		add_item(MODE_ELEMENT, 32'd0, {FieldPrime - 64'd1, 192'd0}, 1'b1);
		add_item(MODE_SIBLING, 32'd0, ones, 1'b1);
		add_item(MODE_START, 32'd2, '0, 1'b0);
		add_item(MODE_ELEMENT, 32'd0, {64'd0, 192'd0}, 1'b1);
		add_item(MODE_ELEMENT, 32'd0, '0, 1'b1);
		add_item(MODE_START, 32'd3, '0, 1'b0);
		add_item(2'd3, 32'd0, '0, 1'b1);
		drain();

		set_config(1'b1, ones);
		add_item(MODE_START, 32'd1, '0, 1'b0);
		add_item(MODE_ELEMENT, 32'd0, {FieldPrime + 64'd3, ones[63:0], 128'd0}, 1'b1);
		for (int k = 0; k < 3; k++)
			void'(add_path(1'b1));
		drain();

		random_phase(1'b1, 283);
		drain();
		send_idle = 52;
		recv_idle = 33;
		random_phase(1'b0, 283);
		drain();
		send_idle = 0;
		recv_idle = 0;
		random_phase(1'b1, 284);
		drain();

		if (fails == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
